FILE: rtl/ctre_pkg.sv
// Package: constants, request/result types and sequencer states for the tag directory.
package ctre_pkg;
  localparam int unsigned LINES = 16;
  localparam int unsigned LINE_W = 4;
  localparam int unsigned BLOCK_SHIFT = 6;
  localparam int unsigned TAG_W = 26;
  localparam logic [15:0] LFSR_MASK = 16'hB400;

  localparam logic [1:0] POL_RANDOM = 2'd0;
  localparam logic [1:0] POL_FIFO = 2'd1;
  localparam logic [1:0] POL_LRU = 2'd2;
  localparam logic [1:0] POL_SECOND = 2'd3;

  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_WAYS = 1'b1;

  typedef struct packed {
    logic [31:0] address;
    logic        is_write;
    logic [31:0] access_time;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  way_used;
    logic        writeback_needed;
    logic [31:0] writeback_address;
    logic [31:0] fill_address;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SEARCH,
    ST_UPDATE
  } state_t;
endpackage

FILE: rtl/cache_tag_replacement_engine.sv
// Top level: tag directory of a write-back cache with an iterative victim search.
// A lookup compares the ways of the set in order; a miss runs the victim search, then the update.
// Search: random takes the LFSR, fifo and lru scan all ways, second chance clears set bits until one is clear.
// One way is examined per cycle by a single compare unit; busy is high meanwhile.
// A new request is taken only in idle, once the previous one has finished, at the earliest while done is high.
// Reset: synchronous; clears valid, dirty, access stamps, second-chance bits, registers,
// fill stamps to minus one, LFSR = 1.
module cache_tag_replacement_engine import ctre_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        req,
  output logic        done,
  output res_t        res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_data
);
  logic [1:0] policy;
  logic [2:0] ways_log2;
  logic [LINES-1:0] line_valid, line_dirty, sc_bit;
  logic [TAG_W-1:0] line_tag [LINES];
  logic [31:0] access_stamp [LINES];
  logic [32:0] fill_stamp [LINES];
  logic [15:0] lfsr;

  state_t state, state_next;
  req_t   cur;
  logic [4:0] ways;
  logic [2:0] lg;
  logic [3:0] way_mask;
  logic [3:0] idx;
  logic [3:0] best;
  logic [3:0] set_bits;
  logic [LINE_W-1:0] base, ln, bln;
  logic [31:0] tag_full;
  logic [TAG_W-1:0] tag;
  logic match, last, sc_clear;

  assign lg = (ways_log2 > 3'd4) ? 3'd4 : ways_log2;
  assign ways = 5'd1 << lg;
  assign way_mask = 4'(ways - 5'd1);
  assign set_bits = cur.address[BLOCK_SHIFT+3:BLOCK_SHIFT] & (4'hF >> lg);
  assign base = set_bits << lg;
  assign tag_full = cur.address >> (BLOCK_SHIFT + 32'(3'd4 - lg));
  assign tag = tag_full[TAG_W-1:0];
  assign ln = base | (idx & way_mask);
  assign bln = base | (best & way_mask);
  assign match = line_valid[ln] && line_tag[ln] == tag;
  assign last = (idx & way_mask) == way_mask;
  assign cfg_ready = 1'b1;
  assign busy = state != ST_IDLE;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (start) state_next = ST_LOOKUP;
      ST_LOOKUP: if (match) state_next = ST_IDLE;
                 else if (last) state_next = ST_SEARCH;
      ST_SEARCH: begin
        if (policy == POL_RANDOM) state_next = ST_UPDATE;
        else if (policy == POL_SECOND) begin
          if (!sc_bit[ln]) state_next = ST_UPDATE;
        end else if (last) state_next = ST_UPDATE;
      end
      ST_UPDATE: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  assign sc_clear = state == ST_SEARCH && policy == POL_SECOND && sc_bit[ln];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      policy <= 2'd0;
      ways_log2 <= 3'd0;
      line_valid <= '0;
      line_dirty <= '0;
      sc_bit <= '0;
      lfsr <= 16'd1;
      done <= 1'b0;
      for (int i = 0; i < LINES; i++) begin
        access_stamp[i] <= '0;
        fill_stamp[i] <= '1;
      end
    end else begin
      state <= state_next;
      done <= 1'b0;
      if (cfg_valid) begin
        if (cfg_index == REG_POLICY) policy <= cfg_data[1:0];
        else ways_log2 <= cfg_data;
      end
      case (state)
        ST_IDLE: if (start) begin
          cur <= req;
          idx <= '0;
        end
        ST_LOOKUP: begin
          if (match) begin
            access_stamp[ln] <= cur.access_time;
            sc_bit[ln] <= 1'b1;
            if (cur.is_write) line_dirty[ln] <= 1'b1;
            done <= 1'b1;
            res <= '{1'b1, idx & way_mask, 1'b0, 32'd0, 32'd0};
          end else if (last) begin
            idx <= '0;
            best <= '0;
            if (policy == POL_RANDOM) begin
              lfsr <= (lfsr >> 1) ^ (lfsr[0] ? LFSR_MASK : 16'd0);
            end
          end else idx <= idx + 4'd1;
        end
        ST_SEARCH: begin
          if (policy == POL_RANDOM) best <= lfsr[3:0] & way_mask;
          else if (policy == POL_FIFO) begin
            if ($signed(fill_stamp[ln]) < $signed(fill_stamp[bln])) best <= idx;
            idx <= idx + 4'd1;
          end else if (policy == POL_LRU) begin
            if (access_stamp[ln] < access_stamp[bln]) best <= idx;
            idx <= idx + 4'd1;
          end else begin
            if (sc_clear) begin
              sc_bit[ln] <= 1'b0;
              idx <= (idx + 4'd1) & way_mask;
            end else best <= idx & way_mask;
          end
        end
        ST_UPDATE: begin
          done <= 1'b1;
          res.hit <= 1'b0;
          res.way_used <= best & way_mask;
          res.writeback_needed <= line_valid[bln] & line_dirty[bln];
          res.writeback_address <= (line_valid[bln] & line_dirty[bln]) ?
            ((32'(line_tag[bln]) << (32'(3'd4 - lg))) | 32'(set_bits)) << BLOCK_SHIFT
            : 32'd0;
          res.fill_address <= {cur.address[31:BLOCK_SHIFT], {BLOCK_SHIFT{1'b0}}};
          line_valid[bln] <= 1'b1;
          line_dirty[bln] <= cur.is_write;
          line_tag[bln] <= tag;
          access_stamp[bln] <= cur.access_time;
          if (policy == POL_FIFO) fill_stamp[bln] <= {1'b0, cur.access_time};
        end
        default: ;
      endcase
    end
  end
endmodule

FILE: bench/cache_tag_replacement_engine_test.sv
// Self-checking bench for the cache tag directory: predicted lookups and victims versus DUT.
module cache_tag_replacement_engine_test import ctre_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic done;
  res_t res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = REG_POLICY;
  logic [2:0] cfg_data = '0;

  cache_tag_replacement_engine dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // directory model
  logic        dir_valid [LINES];
  logic        dir_dirty [LINES];
  logic [31:0] dir_tag [LINES];
  logic [31:0] dir_used [LINES];
  logic signed [32:0] dir_filled [LINES];
  logic        dir_chance [LINES];
  logic [15:0] rnd_lfsr;
  logic [1:0]  cur_policy;
  logic [2:0]  cur_ways_log2;

  req_t request_queue [$];
  res_t expected_results [$];
  int   error_count = 0;
  int   tick_count = 0;
  bit   hold_sender = 1'b0;
  bit   quiet_tail = 1'b0;
  bit   stimulus_done = 1'b0;
  int   send_gap = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic res_t predict_lookup(input req_t r);
    res_t o;
    int ways, sets, set_no, base, v;
    logic [31:0] tag;
    o = '0;
    ways = 1 << ((cur_ways_log2 > 3'd4) ? 4 : int'(cur_ways_log2));
    sets = LINES / ways;
    set_no = (r.address >> BLOCK_SHIFT) % sets;
    tag = r.address / (32'd64 * sets);
    base = set_no * ways;
    for (int i = 0; i < ways; i++) begin
      if (dir_valid[base+i] && dir_tag[base+i] == tag) begin
        dir_used[base+i] = r.access_time;
        dir_chance[base+i] = 1'b1;
        if (r.is_write) dir_dirty[base+i] = 1'b1;
        o.hit = 1'b1;
        o.way_used = i[3:0];
        return o;
      end
    end
    v = 0;
    case (cur_policy)
      POL_RANDOM: begin
        rnd_lfsr = (rnd_lfsr >> 1) ^ (rnd_lfsr[0] ? LFSR_MASK : 16'h0);
        v = rnd_lfsr % ways;
      end
      POL_FIFO: begin
        for (int i = 1; i < ways; i++)
          if (dir_filled[base+i] < dir_filled[base+v]) v = i;
        dir_filled[base+v] = $signed({1'b0, r.access_time});
      end
      POL_LRU: begin
        for (int i = 1; i < ways; i++)
          if (dir_used[base+i] < dir_used[base+v]) v = i;
      end
      default: begin
        while (dir_chance[base+v]) begin
          dir_chance[base+v] = 1'b0;
          v = (v + 1) % ways;
        end
      end
    endcase
    o.way_used = v[3:0];
    if (dir_valid[base+v] && dir_dirty[base+v]) begin
      o.writeback_needed = 1'b1;
      o.writeback_address = (dir_tag[base+v] * sets + set_no) * 32'd64;
    end
    o.fill_address = {r.address[31:6], 6'd0};
    dir_valid[base+v] = 1'b1;
    dir_dirty[base+v] = r.is_write;
    dir_tag[base+v] = tag;
    dir_used[base+v] = r.access_time;
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      // request taken this edge
      expected_results.push_back(predict_lookup(req));
      if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        start <= 1'b0;
        send_gap = $urandom_range(1, 17);
      end else if (request_queue.size() > 0 && !hold_sender) begin
        req <= request_queue.pop_front();
      end else begin
        start <= 1'b0;
      end
    end else if (!start) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (request_queue.size() > 0 && !hold_sender) begin
        req <= request_queue.pop_front();
        start <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", res.fill_address, 32'h0);
      end else begin
        res_t e;
        e = expected_results.pop_front();
        if (res.hit !== e.hit) report_mismatch("hit", 32'(res.hit), 32'(e.hit));
        if (res.way_used !== e.way_used)
          report_mismatch("way_used", 32'(res.way_used), 32'(e.way_used));
        if (res.writeback_needed !== e.writeback_needed)
          report_mismatch("writeback_needed", 32'(res.writeback_needed),
                          32'(e.writeback_needed));
        if (res.writeback_address !== e.writeback_address)
          report_mismatch("writeback_address", res.writeback_address, e.writeback_address);
        if (res.fill_address !== e.fill_address)
          report_mismatch("fill_address", res.fill_address, e.fill_address);
      end
    end
  end

  always @(posedge clk) begin
    tick_count++;
    if (tick_count > 400000) begin
      $display("timeout");
      $display("FAIL");
      $finish;
    end
  end

  function automatic req_t make_access(input logic [31:0] a, input logic w);
    req_t r;
    r.address = a;
    r.is_write = w;
    r.access_time = $urandom();
    return r;
  endfunction

  task automatic wait_drained();
    while (request_queue.size() > 0 || start || busy || expected_results.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [2:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_POLICY) cur_policy = val[1:0];
    else cur_ways_log2 = val;
  endtask

  // random addresses, mostly from a few hot regions, so hits and conflicts occur
  function automatic logic [31:0] pick_address();
    logic [31:0] a;
    a = $urandom();
    if ($urandom_range(0, 3) != 0) a = {20'(($urandom_range(0, 11)) * 32'h0001_7), a[11:0]};
    return a;
  endfunction

  initial begin
    for (int i = 0; i < LINES; i++) begin
      dir_valid[i] = 1'b0;
      dir_dirty[i] = 1'b0;
      dir_tag[i] = '0;
      dir_used[i] = '0;
      dir_filled[i] = -33'sd1;
      dir_chance[i] = 1'b0;
    end
    rnd_lfsr = 16'd1;
    cur_policy = POL_RANDOM;
    cur_ways_log2 = 3'd0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes under the reset geometry
    request_queue.push_back('{32'h0, 1'b1, 32'h0});
    request_queue.push_back('{32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF});
    request_queue.push_back('{32'h0000_0004, 1'b0, 32'h1});
    request_queue.push_back('{32'h0000_0400, 1'b0, 32'h2});
    request_queue.push_back('{32'hFFFF_FFC0, 1'b0, 32'h3});
    request_queue.push_back('{32'h0000_0000, 1'b1, 32'h8000_0000});
    request_queue.push_back('{32'hAAAA_AAAA, 1'b0, 32'h5555_5555});
    request_queue.push_back('{32'h5555_5555, 1'b1, 32'hAAAA_AAAA});
    wait_drained();

    // every policy, ways_log2 from 0 to 7 including oversized values
    for (int ph = 0; ph < 16; ph++) begin
      write_reg(REG_POLICY, 3'(ph % 4));
      write_reg(REG_WAYS, 3'(ph / 2));
      for (int k = 0; k < 28; k++)
        request_queue.push_back(make_access(pick_address(), 1'($urandom_range(0, 1))));
      if (ph == 5) begin
        // sender waits mid-stream until all results are in before resuming
        while (request_queue.size() > 14) @(posedge clk);
        hold_sender = 1'b1;
        while (expected_results.size() > 0 || busy || start) @(posedge clk);
        hold_sender = 1'b0;
      end
      if (ph == 14) quiet_tail = 1'b1;
      wait_drained();
    end
    write_reg(REG_WAYS, 3'd4);
    write_reg(REG_POLICY, {1'b0, POL_SECOND});
    for (int k = 0; k < 20; k++)
      request_queue.push_back(make_access(pick_address(), 1'($urandom_range(0, 1))));
    wait_drained();

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
